// ===== src/dirichlet_kernel_bin_value_assert.svh =====
// assertion macros for the periodic sinc bin value block
`ifndef DIRICHLET_KERNEL_BIN_VALUE_ASSERT_SVH
`define DIRICHLET_KERNEL_BIN_VALUE_ASSERT_SVH

// implication in the same cycle, checked out of reset
`define DKBV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication in the following cycle, checked during reset too
`define DKBV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dkbv_pkg.sv =====
// shared types, constants and arithmetic helpers of the periodic sinc block
`timescale 1ns / 1ps
package dkbv_pkg;

  localparam int MAX_FFT_LOG2_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_FFT_SIZE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COSINE_BASIS = 1'b1;
  localparam logic [CFG_DATA_W-1:0] FFT_SIZE_RST    = 17'd1024;

  localparam int FREQ_W  = 32;
  localparam int PHASE_W = 16;
  localparam int BIN_W   = 16;
  localparam int VAL_W   = 34;

  localparam int TH_STEPS   = 79;
  localparam int SIN_LAT    = 25;
  localparam int QDIV_STEPS = 33;

  localparam logic [63:0] HALF_TURN    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUARTER_TURN = 64'h4000_0000_0000_0000;
  localparam logic [63:0] EIGHTH_TURN  = 64'h2000_0000_0000_0000;
  localparam logic [63:0] PI62         = 64'hC90F_DAA2_2168_C235;

  localparam logic [63:0] TF0  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TF1  = TF0 / 64'd1;
  localparam logic [63:0] TF2  = TF1 / 64'd2;
  localparam logic [63:0] TF3  = TF2 / 64'd3;
  localparam logic [63:0] TF4  = TF3 / 64'd4;
  localparam logic [63:0] TF5  = TF4 / 64'd5;
  localparam logic [63:0] TF6  = TF5 / 64'd6;
  localparam logic [63:0] TF7  = TF6 / 64'd7;
  localparam logic [63:0] TF8  = TF7 / 64'd8;
  localparam logic [63:0] TF9  = TF8 / 64'd9;
  localparam logic [63:0] TF10 = TF9 / 64'd10;
  localparam logic [63:0] TF11 = TF10 / 64'd11;
  localparam logic [63:0] TF12 = TF11 / 64'd12;
  localparam logic [63:0] TF13 = TF12 / 64'd13;
  localparam logic [63:0] TF14 = TF13 / 64'd14;
  localparam logic [63:0] TF15 = TF14 / 64'd15;
  localparam logic [63:0] TF16 = TF15 / 64'd16;
  localparam logic [63:0] TF17 = TF16 / 64'd17;
  localparam logic [63:0] TF18 = TF17 / 64'd18;

  localparam logic [63:0] TAYLOR_F [0:18] = '{
    TF0, TF1, TF2, TF3, TF4, TF5, TF6, TF7, TF8, TF9,
    TF10, TF11, TF12, TF13, TF14, TF15, TF16, TF17, TF18
  };

  typedef struct packed {
    logic [FREQ_W-1:0]  m;
    logic               neg;
    logic [PHASE_W-1:0] ph;
    logic               zero;
  } dkbv_item_t;

  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } dkbv_pp_t;

  function automatic dkbv_pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    dkbv_pp_t pp;
    pp.p00 = {32'b0, a[31:0]} * {32'b0, b[31:0]};
    pp.p01 = {32'b0, a[31:0]} * {32'b0, b[63:32]};
    pp.p10 = {32'b0, a[63:32]} * {32'b0, b[31:0]};
    pp.p11 = {32'b0, a[63:32]} * {32'b0, b[63:32]};
    return pp;
  endfunction

  function automatic logic [127:0] mul_sum(input dkbv_pp_t pp);
    return {64'b0, pp.p00} + {32'b0, pp.p01, 32'b0} + {32'b0, pp.p10, 32'b0}
           + {pp.p11, 64'b0};
  endfunction

  function automatic logic [63:0] q62_hi(input dkbv_pp_t pp);
    logic [127:0] s;
    s = mul_sum(pp);
    return s[125:62];
  endfunction

  function automatic logic [63:0] rad_hi(input dkbv_pp_t pp);
    logic [127:0] s;
    s = mul_sum(pp);
    return s[126:63];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [VAL_W-1:0] q16_round(input logic [63:0] v);
    logic [63:0] m;
    m = (mag64(v) + 64'h0000_2000_0000_0000) >> 46;
    return v[63] ? (VAL_W'(0) - m[VAL_W-1:0]) : m[VAL_W-1:0];
  endfunction

endpackage

// ===== src/dirichlet_kernel_bin_value.sv =====
// top level of the periodic sinc (dirichlet kernel) bin value block
//
// use:
//   input: a word is taken at a rising edge with start high and busy low;
//   it carries a q16.16 frequency, a phase in 1/65536 turns and a bin index.
//   config: cfg_valid/cfg_ready write channel; index 0 is the fft size,
//   index 1 the cosine basis select. write only while no word is in flight.
//   result: out_valid is high for one cycle per word with value_real,
//   value_imag (q17.16, saturated) and pole_flag; the receiver cannot stall.
// timing:
//   one word per cycle sustained. from the accepting edge a word passes the
//   front register, queue, divider load and 79-step angle divider by the fft
//   size, angle sum register, taylor sine units, 64-bit product registers,
//   load and 33 steps of the q16 divider and the output register, where
//   out_valid rises. busy rises only if the queue fills, which the back end
//   never lets happen.
// reset:
//   rst_n low clears the pipeline valids and loads fft size 1024 and cosine
//   basis 1; words in flight are dropped.
`timescale 1ns / 1ps
module dirichlet_kernel_bin_value #(
  parameter int MAX_FFT_LOG2 = dkbv_pkg::MAX_FFT_LOG2_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [dkbv_pkg::FREQ_W-1:0]     in_true_frequency,
  input  logic [dkbv_pkg::PHASE_W-1:0]    in_start_phase,
  input  logic [dkbv_pkg::BIN_W-1:0]      in_bin_index,
  output logic                            out_valid,
  output logic [dkbv_pkg::VAL_W-1:0]      out_value_real,
  output logic [dkbv_pkg::VAL_W-1:0]      out_value_imag,
  output logic                            out_pole_flag,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dkbv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dkbv_pkg::CFG_DATA_W-1:0] cfg_data
);
  logic                 q_full;
  logic                 q_push;
  dkbv_pkg::dkbv_item_t q_item_in;
  logic                 q_vld;
  dkbv_pkg::dkbv_item_t q_item_out;
  logic [MAX_FFT_LOG2:0] fft_n;
  logic                 cos_basis;

  dkbv_front #(.MAX_FFT_LOG2(MAX_FFT_LOG2)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_true_frequency (in_true_frequency),
    .in_start_phase    (in_start_phase),
    .in_bin_index      (in_bin_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_item_in),
    .fft_n             (fft_n),
    .cosine_basis      (cos_basis)
  );

  dkbv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item_in),
    .full      (q_full),
    .pop_vld   (q_vld),
    .pop_item  (q_item_out)
  );

  dkbv_back #(.MAX_FFT_LOG2(MAX_FFT_LOG2)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_vld          (q_vld),
    .q_item         (q_item_out),
    .fft_n          (fft_n),
    .cosine_basis   (cos_basis),
    .out_valid      (out_valid),
    .out_value_real (out_value_real),
    .out_value_imag (out_value_imag),
    .out_pole_flag  (out_pole_flag)
  );

endmodule

// ===== src/dkbv_front.sv =====
// front end: config registers, word acceptance and offset classification
`timescale 1ns / 1ps
module dkbv_front #(
  parameter int MAX_FFT_LOG2 = dkbv_pkg::MAX_FFT_LOG2_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [dkbv_pkg::FREQ_W-1:0]        in_true_frequency,
  input  logic [dkbv_pkg::PHASE_W-1:0]       in_start_phase,
  input  logic [dkbv_pkg::BIN_W-1:0]         in_bin_index,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dkbv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dkbv_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               q_full,
  output logic                               q_push,
  output dkbv_pkg::dkbv_item_t               q_item,
  output logic [MAX_FFT_LOG2:0]              fft_n,
  output logic                               cosine_basis
);
  localparam int NW = MAX_FFT_LOG2 + 1;
  localparam int CW = (NW > dkbv_pkg::CFG_DATA_W) ? NW : dkbv_pkg::CFG_DATA_W;
  localparam logic [CW-1:0] NMAX = CW'(1) << MAX_FFT_LOG2;
  localparam logic [CW-1:0] NMIN = CW'(2);

  logic [dkbv_pkg::CFG_DATA_W-1:0] fft_size_r;
  logic                            cos_basis_r;
  logic [NW-1:0]                   fft_n_r;
  logic                            fr_vld_r;
  dkbv_pkg::dkbv_item_t            fr_item_r;
  dkbv_pkg::dkbv_item_t            item_nxt;
  logic                            accept;
  logic [dkbv_pkg::FREQ_W-1:0]     bin_q;
  logic [CW-1:0]                   size_ext;

  assign cfg_ready    = 1'b1;
  assign busy         = fr_vld_r & q_full;
  assign accept       = start & ~busy;
  assign q_push       = fr_vld_r & ~q_full;
  assign q_item       = fr_item_r;
  assign fft_n        = fft_n_r;
  assign cosine_basis = cos_basis_r;

  // offset magnitude, direction and the exact zero case
  always_comb begin
    bin_q         = {in_bin_index, 16'b0};
    item_nxt.neg  = in_true_frequency < bin_q;
    item_nxt.m    = item_nxt.neg ? (bin_q - in_true_frequency) : (in_true_frequency - bin_q);
    item_nxt.ph   = in_start_phase;
    item_nxt.zero = (item_nxt.m == '0);
    size_ext      = CW'(fft_size_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fft_size_r  <= dkbv_pkg::FFT_SIZE_RST;
      cos_basis_r <= 1'b1;
      fr_vld_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dkbv_pkg::CFG_FFT_SIZE:     fft_size_r  <= cfg_data;
          dkbv_pkg::CFG_COSINE_BASIS: cos_basis_r <= cfg_data[0];
          default: ;
        endcase
      end
      fr_vld_r <= accept | (fr_vld_r & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r <= item_nxt;
    end
    if (size_ext < NMIN) begin
      fft_n_r <= NW'(NMIN);
    end else if (size_ext > NMAX) begin
      fft_n_r <= NW'(NMAX);
    end else begin
      fft_n_r <= NW'(size_ext);
    end
  end

endmodule

// ===== src/dkbv_queue.sv =====
// two-entry queue between the front end and the arithmetic back end
`timescale 1ns / 1ps
module dkbv_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dkbv_pkg::dkbv_item_t push_item,
  output logic                 full,
  output logic                 pop_vld,
  output dkbv_pkg::dkbv_item_t pop_item
);
  dkbv_pkg::dkbv_item_t mem_r [0:1];
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [1:0]           cnt_r;
  logic [1:0]           cnt_nxt;

  // back end takes a word every cycle one is present
  assign pop_vld  = (cnt_r != 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop_vld};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_vld) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/dkbv_sin.sv =====
// pipelined sine of a turn angle, taylor series in horner form, signed q2.62
`timescale 1ns / 1ps
module dkbv_sin (
  input  logic        clk,
  input  logic [63:0] angle,
  output logic [63:0] sine
);
  logic [63:0]        fold_a;
  logic [63:0]        fold_x;
  logic               fold_odd;

  logic [63:0]        x_r;
  logic               odd1_r, neg1_r;
  dkbv_pkg::dkbv_pp_t rad_pp_r;
  logic               odd2_r, neg2_r;
  logic [63:0]        t_r;
  logic               odd3_r, neg3_r;
  dkbv_pkg::dkbv_pp_t t2_pp_r;
  logic [63:0]        t4_r;
  logic               odd4_r, neg4_r;

  logic [63:0]        hs_r   [0:9];
  logic [63:0]        ht2_r  [0:9];
  logic [63:0]        ht_r   [0:9];
  logic               hodd_r [0:9];
  logic               hneg_r [0:9];

  dkbv_pkg::dkbv_pp_t ha_pp_r  [0:8];
  logic [63:0]        ha_s_r   [0:8];
  logic [63:0]        ha_t2_r  [0:8];
  logic [63:0]        ha_t_r   [0:8];
  logic               ha_odd_r [0:8];
  logic               ha_neg_r [0:8];

  dkbv_pkg::dkbv_pp_t fpp_r;
  logic [63:0]        fs_r;
  logic               fodd_r, fneg_r;
  logic [63:0]        fr;
  logic [63:0]        sine_r;

  // fold into the first eighth turn, pick sine or cosine series
  always_comb begin
    fold_a = {1'b0, angle[62:0]};
    if (fold_a > dkbv_pkg::QUARTER_TURN) begin
      fold_a = dkbv_pkg::HALF_TURN - fold_a;
    end
    fold_odd = (fold_a <= dkbv_pkg::EIGHTH_TURN);
    fold_x   = fold_odd ? fold_a : (dkbv_pkg::QUARTER_TURN - fold_a);
    fr       = fodd_r ? dkbv_pkg::q62_hi(fpp_r) : fs_r;
  end

  assign sine = sine_r;

  always_ff @(posedge clk) begin
    x_r      <= fold_x;
    odd1_r   <= fold_odd;
    neg1_r   <= angle[63];
    rad_pp_r <= dkbv_pkg::mul_pp(x_r, dkbv_pkg::PI62);
    odd2_r   <= odd1_r;
    neg2_r   <= neg1_r;
    t_r      <= dkbv_pkg::rad_hi(rad_pp_r);
    odd3_r   <= odd2_r;
    neg3_r   <= neg2_r;
    t2_pp_r  <= dkbv_pkg::mul_pp(t_r, t_r);
    t4_r     <= t_r;
    odd4_r   <= odd3_r;
    neg4_r   <= neg3_r;
    hs_r[0]   <= odd4_r ? dkbv_pkg::TF17 : dkbv_pkg::TF18;
    ht2_r[0]  <= dkbv_pkg::q62_hi(t2_pp_r);
    ht_r[0]   <= t4_r;
    hodd_r[0] <= odd4_r;
    hneg_r[0] <= neg4_r;
    for (int j = 0; j < 9; j++) begin
      ha_pp_r[j]  <= dkbv_pkg::mul_pp(ht2_r[j], hs_r[j]);
      ha_s_r[j]   <= hs_r[j];
      ha_t2_r[j]  <= ht2_r[j];
      ha_t_r[j]   <= ht_r[j];
      ha_odd_r[j] <= hodd_r[j];
      ha_neg_r[j] <= hneg_r[j];
      // the sine series has one term fewer: its first step passes through
      if (j == 0 && ha_odd_r[j]) begin
        hs_r[j+1] <= ha_s_r[j];
      end else if (ha_odd_r[j]) begin
        hs_r[j+1] <= dkbv_pkg::TAYLOR_F[5'(17 - 2 * j)] - dkbv_pkg::q62_hi(ha_pp_r[j]);
      end else begin
        hs_r[j+1] <= dkbv_pkg::TAYLOR_F[5'(16 - 2 * j)] - dkbv_pkg::q62_hi(ha_pp_r[j]);
      end
      ht2_r[j+1]  <= ha_t2_r[j];
      ht_r[j+1]   <= ha_t_r[j];
      hodd_r[j+1] <= ha_odd_r[j];
      hneg_r[j+1] <= ha_neg_r[j];
    end
    fpp_r  <= dkbv_pkg::mul_pp(ht_r[9], hs_r[9]);
    fs_r   <= hs_r[9];
    fodd_r <= hodd_r[9];
    fneg_r <= hneg_r[9];
    sine_r <= fneg_r ? (64'd0 - fr) : fr;
  end

endmodule

// ===== src/dkbv_back.sv =====
// back end: angle divider, four sine units, product, q16 divide and output word
`timescale 1ns / 1ps
module dkbv_back #(
  parameter int MAX_FFT_LOG2 = dkbv_pkg::MAX_FFT_LOG2_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_vld,
  input  dkbv_pkg::dkbv_item_t             q_item,
  input  logic [MAX_FFT_LOG2:0]            fft_n,
  input  logic                             cosine_basis,
  output logic                             out_valid,
  output logic [dkbv_pkg::VAL_W-1:0]       out_value_real,
  output logic [dkbv_pkg::VAL_W-1:0]       out_value_imag,
  output logic                             out_pole_flag
);
  localparam int NW  = MAX_FFT_LOG2 + 1;
  localparam int DST = dkbv_pkg::TH_STEPS;
  localparam int QST = dkbv_pkg::QDIV_STEPS;
  localparam int SL  = dkbv_pkg::SIN_LAT;
  localparam int VW  = dkbv_pkg::VAL_W;

  // angle divider: floor(m * 2^47 / n), one quotient bit a stage
  logic          dv_r    [0:DST];
  logic [31:0]   dm_r    [0:DST];
  logic          dneg_r  [0:DST];
  logic [15:0]   dph_r   [0:DST];
  logic          dzero_r [0:DST];
  logic [NW-1:0] drem_r  [0:DST];
  logic [63:0]   dquo_r  [0:DST];
  logic [NW-1:0] drem_nxt [0:DST-1];
  logic [63:0]   dquo_nxt [0:DST-1];

  logic          th_vld_r, th_zero_r;
  logic [63:0]   th1_r, th2_r, th3_r, th3c_r;
  logic [63:0]   th1_nxt, th2_nxt;

  logic          sdv_r [0:SL-1];
  logic          sdz_r [0:SL-1];
  logic [63:0]   s_num, s_den, s_cs, s_sn;

  logic               p1_v_r, p1_zero_r, p1_pole_r, p1_negre_r, p1_negim_r;
  dkbv_pkg::dkbv_pp_t p1_ppre_r, p1_ppim_r;
  logic [63:0]        p1_den_r;
  logic [VW-1:0]      p1_zre_r, p1_zim_r;

  logic          p2_v_r, p2_zero_r, p2_pole_r, p2_negre_r, p2_negim_r;
  logic [63:0]   p2_prre_r, p2_prim_r, p2_den_r;
  logic [VW-1:0] p2_zre_r, p2_zim_r;

  // q16 quotient: 33 bits of floor(prod * 2^17 / den)
  logic          qv_r     [0:QST];
  logic          qzero_r  [0:QST];
  logic          qpole_r  [0:QST];
  logic          qnegre_r [0:QST];
  logic          qnegim_r [0:QST];
  logic          qsatre_r [0:QST];
  logic          qsatim_r [0:QST];
  logic [VW-1:0] qzre_r   [0:QST];
  logic [VW-1:0] qzim_r   [0:QST];
  logic [63:0]   qden_r   [0:QST];
  logic [63:0]   qremre_r [0:QST];
  logic [63:0]   qremim_r [0:QST];
  logic [15:0]   qlore_r  [0:QST];
  logic [15:0]   qloim_r  [0:QST];
  logic [32:0]   qaccre_r [0:QST];
  logic [32:0]   qaccim_r [0:QST];
  logic [63:0]   qremre_nxt [0:QST-1];
  logic [63:0]   qremim_nxt [0:QST-1];
  logic [32:0]   qaccre_nxt [0:QST-1];
  logic [32:0]   qaccim_nxt [0:QST-1];

  logic [32:0]   mag_re, mag_im;
  logic [33:0]   rnd_re, rnd_im;
  logic [VW-1:0] val_re, val_im;

  logic          out_valid_r;
  logic [VW-1:0] out_re_r, out_im_r;
  logic          out_pole_r;

  assign out_valid      = out_valid_r;
  assign out_value_real = out_re_r;
  assign out_value_imag = out_im_r;
  assign out_pole_flag  = out_pole_r;

  always_comb begin
    logic [31:0]   dsh;
    logic [NW-1:0] dtry;
    for (int s = 0; s < DST; s++) begin
      dsh  = dm_r[s] << s;
      dtry = {drem_r[s][NW-2:0], dsh[31]};
      if (dtry >= fft_n) begin
        drem_nxt[s] = dtry - fft_n;
        dquo_nxt[s] = {dquo_r[s][62:0], 1'b1};
      end else begin
        drem_nxt[s] = dtry;
        dquo_nxt[s] = {dquo_r[s][62:0], 1'b0};
      end
    end
    th1_nxt = {dm_r[DST][16:0], 47'b0};
    th2_nxt = dquo_r[DST];
    if (dneg_r[DST]) begin
      th1_nxt = 64'd0 - th1_nxt;
      th2_nxt = 64'd0 - th2_nxt;
    end
  end

  always_comb begin
    logic [64:0] rtry_re, rtry_im;
    logic        ge_re, ge_im;
    for (int s = 0; s < QST; s++) begin
      rtry_re = {qremre_r[s], qlore_r[s][15]};
      rtry_im = {qremim_r[s], qloim_r[s][15]};
      ge_re   = rtry_re >= {1'b0, qden_r[s]};
      ge_im   = rtry_im >= {1'b0, qden_r[s]};
      qremre_nxt[s] = ge_re ? 64'(rtry_re - {1'b0, qden_r[s]}) : rtry_re[63:0];
      qremim_nxt[s] = ge_im ? 64'(rtry_im - {1'b0, qden_r[s]}) : rtry_im[63:0];
      qaccre_nxt[s] = {qaccre_r[s][31:0], ge_re};
      qaccim_nxt[s] = {qaccim_r[s][31:0], ge_im};
    end
    rnd_re = ({1'b0, qaccre_r[QST]} + 34'd1) >> 1;
    rnd_im = ({1'b0, qaccim_r[QST]} + 34'd1) >> 1;
    mag_re = qsatre_r[QST] ? 33'h1_0000_0000 : rnd_re[32:0];
    mag_im = qsatim_r[QST] ? 33'h1_0000_0000 : rnd_im[32:0];
    val_re = qnegre_r[QST] ? (VW'(0) - {1'b0, mag_re}) : {1'b0, mag_re};
    val_im = qnegim_r[QST] ? (VW'(0) - {1'b0, mag_im}) : {1'b0, mag_im};
  end

  dkbv_sin u_sin_num (.clk(clk), .angle(th1_r),  .sine(s_num));
  dkbv_sin u_sin_den (.clk(clk), .angle(th2_r),  .sine(s_den));
  dkbv_sin u_sin_cs  (.clk(clk), .angle(th3c_r), .sine(s_cs));
  dkbv_sin u_sin_sn  (.clk(clk), .angle(th3_r),  .sine(s_sn));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DST; s++) begin
        dv_r[s] <= 1'b0;
      end
      th_vld_r <= 1'b0;
      for (int s = 0; s < SL; s++) begin
        sdv_r[s] <= 1'b0;
      end
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      for (int s = 0; s <= QST; s++) begin
        qv_r[s] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      dv_r[0] <= q_vld;
      for (int s = 0; s < DST; s++) begin
        dv_r[s+1] <= dv_r[s];
      end
      th_vld_r <= dv_r[DST];
      sdv_r[0] <= th_vld_r;
      for (int s = 0; s < SL - 1; s++) begin
        sdv_r[s+1] <= sdv_r[s];
      end
      p1_v_r  <= sdv_r[SL-1];
      p2_v_r  <= p1_v_r;
      qv_r[0] <= p2_v_r;
      for (int s = 0; s < QST; s++) begin
        qv_r[s+1] <= qv_r[s];
      end
      out_valid_r <= qv_r[QST];
    end
  end

  always_ff @(posedge clk) begin
    dm_r[0]    <= q_item.m;
    dneg_r[0]  <= q_item.neg;
    dph_r[0]   <= q_item.ph;
    dzero_r[0] <= q_item.zero;
    drem_r[0]  <= '0;
    dquo_r[0]  <= '0;
    for (int s = 0; s < DST; s++) begin
      dm_r[s+1]    <= dm_r[s];
      dneg_r[s+1]  <= dneg_r[s];
      dph_r[s+1]   <= dph_r[s];
      dzero_r[s+1] <= dzero_r[s];
      drem_r[s+1]  <= drem_nxt[s];
      dquo_r[s+1]  <= dquo_nxt[s];
    end

    // with a zero offset both angles vanish and the phase stands alone
    th1_r     <= th1_nxt;
    th2_r     <= th2_nxt;
    th3_r     <= th1_nxt + {dph_r[DST], 48'b0} + th2_nxt;
    th3c_r    <= th1_nxt + {dph_r[DST], 48'b0} + th2_nxt + dkbv_pkg::QUARTER_TURN;
    th_zero_r <= dzero_r[DST];

    sdz_r[0] <= th_zero_r;
    for (int s = 0; s < SL - 1; s++) begin
      sdz_r[s+1] <= sdz_r[s];
    end

    p1_zero_r  <= sdz_r[SL-1];
    p1_pole_r  <= (s_den == 64'd0);
    p1_ppre_r  <= dkbv_pkg::mul_pp(dkbv_pkg::mag64(s_num), dkbv_pkg::mag64(s_cs));
    p1_ppim_r  <= dkbv_pkg::mul_pp(dkbv_pkg::mag64(s_num), dkbv_pkg::mag64(s_sn));
    p1_den_r   <= dkbv_pkg::mag64(s_den);
    p1_negre_r <= s_num[63] ^ s_cs[63] ^ s_den[63];
    p1_negim_r <= s_num[63] ^ s_sn[63] ^ s_den[63] ^ ~cosine_basis;
    p1_zre_r   <= dkbv_pkg::q16_round(s_cs);
    p1_zim_r   <= VW'(0) - dkbv_pkg::q16_round(s_sn);

    p2_zero_r  <= p1_zero_r;
    p2_pole_r  <= p1_pole_r;
    p2_prre_r  <= dkbv_pkg::q62_hi(p1_ppre_r);
    p2_prim_r  <= dkbv_pkg::q62_hi(p1_ppim_r);
    p2_den_r   <= p1_den_r;
    p2_negre_r <= p1_negre_r;
    p2_negim_r <= p1_negim_r;
    p2_zre_r   <= p1_zre_r;
    p2_zim_r   <= p1_zim_r;

    qzero_r[0]  <= p2_zero_r;
    qpole_r[0]  <= p2_pole_r;
    qnegre_r[0] <= p2_negre_r;
    qnegim_r[0] <= p2_negim_r;
    qzre_r[0]   <= p2_zre_r;
    qzim_r[0]   <= p2_zim_r;
    qden_r[0]   <= p2_den_r;
    qsatre_r[0] <= {16'b0, p2_prre_r} >= {p2_den_r, 16'b0};
    qsatim_r[0] <= {16'b0, p2_prim_r} >= {p2_den_r, 16'b0};
    qremre_r[0] <= {16'b0, p2_prre_r[63:16]};
    qremim_r[0] <= {16'b0, p2_prim_r[63:16]};
    qlore_r[0]  <= p2_prre_r[15:0];
    qloim_r[0]  <= p2_prim_r[15:0];
    qaccre_r[0] <= '0;
    qaccim_r[0] <= '0;
    for (int s = 0; s < QST; s++) begin
      qzero_r[s+1]  <= qzero_r[s];
      qpole_r[s+1]  <= qpole_r[s];
      qnegre_r[s+1] <= qnegre_r[s];
      qnegim_r[s+1] <= qnegim_r[s];
      qzre_r[s+1]   <= qzre_r[s];
      qzim_r[s+1]   <= qzim_r[s];
      qden_r[s+1]   <= qden_r[s];
      qsatre_r[s+1] <= qsatre_r[s];
      qsatim_r[s+1] <= qsatim_r[s];
      qremre_r[s+1] <= qremre_nxt[s];
      qremim_r[s+1] <= qremim_nxt[s];
      qlore_r[s+1]  <= {qlore_r[s][14:0], 1'b0};
      qloim_r[s+1]  <= {qloim_r[s][14:0], 1'b0};
      qaccre_r[s+1] <= qaccre_nxt[s];
      qaccim_r[s+1] <= qaccim_nxt[s];
    end

    if (qzero_r[QST]) begin
      out_re_r   <= qzre_r[QST];
      out_im_r   <= qzim_r[QST];
      out_pole_r <= 1'b0;
    end else if (qpole_r[QST]) begin
      out_re_r   <= '0;
      out_im_r   <= '0;
      out_pole_r <= 1'b1;
    end else begin
      out_re_r   <= val_re;
      out_im_r   <= val_im;
      out_pole_r <= 1'b0;
    end
  end

endmodule

// ===== src/dkbv_checker.sv =====
// port-level checks of the periodic sinc block and their binding
`timescale 1ns / 1ps
`include "dirichlet_kernel_bin_value_assert.svh"
module dkbv_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_pole_flag,
  input logic [dkbv_pkg::VAL_W-1:0] out_value_real,
  input logic [dkbv_pkg::VAL_W-1:0] out_value_imag
);
  `DKBV_ASSERT_NXT(a_busy_after_rst, !rst_n, !busy, "busy after reset")
  `DKBV_ASSERT_NXT(a_out_after_rst, !rst_n, !out_valid, "result word after reset")
  `DKBV_ASSERT_IMP(a_pole_zero, out_valid && out_pole_flag, (out_value_real == '0) && (out_value_imag == '0), "pole word not zero")
  `DKBV_ASSERT_IMP(a_real_range, out_valid, ($signed(out_value_real) <= $signed(34'h1_0000_0000)) && ($signed(out_value_real) >= $signed(34'h3_0000_0000)), "real part beyond saturation")
  `DKBV_ASSERT_IMP(a_imag_range, out_valid, ($signed(out_value_imag) <= $signed(34'h1_0000_0000)) && ($signed(out_value_imag) >= $signed(34'h3_0000_0000)), "imaginary part beyond saturation")
endmodule

bind dirichlet_kernel_bin_value dkbv_checker u_dkbv_checker (.*);

// ===== dv/dirichlet_kernel_bin_value_tb.sv =====
// self-checking testbench for the periodic sinc bin value block
`timescale 1ns / 1ps
module dirichlet_kernel_bin_value_tb;

  typedef struct {
    logic [dkbv_pkg::FREQ_W-1:0]  freq;
    logic [dkbv_pkg::PHASE_W-1:0] phase;
    logic [dkbv_pkg::BIN_W-1:0]   bin;
  } bin_word_t;

  typedef struct {
    logic [dkbv_pkg::VAL_W-1:0] re;
    logic [dkbv_pkg::VAL_W-1:0] im;
    logic                       pole;
  } kernel_val_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [dkbv_pkg::FREQ_W-1:0] in_true_frequency = '0;
  logic [dkbv_pkg::PHASE_W-1:0] in_start_phase = '0;
  logic [dkbv_pkg::BIN_W-1:0] in_bin_index = '0;
  logic out_valid;
  logic [dkbv_pkg::VAL_W-1:0] out_value_real;
  logic [dkbv_pkg::VAL_W-1:0] out_value_imag;
  logic out_pole_flag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dkbv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dkbv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bin_word_t pending_words[$];
  kernel_val_t kernel_expected[$];
  logic [16:0] cur_fft_size = 17'd1024;
  logic cur_cos_basis = 1'b1;
  bit idle_on = 1'b1;
  int gap_cnt = 0;
  int errors = 0;

  always #6 clk = ~clk;

  dirichlet_kernel_bin_value DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_true_frequency(in_true_frequency), .in_start_phase(in_start_phase),
    .in_bin_index(in_bin_index), .out_valid(out_valid),
    .out_value_real(out_value_real), .out_value_imag(out_value_imag),
    .out_pole_flag(out_pole_flag), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic [63:0] fix_mul62(logic [63:0] x, logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[125:62];
  endfunction

  function automatic logic [63:0] turn_to_rad(logic [63:0] a);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, 64'hC90F_DAA2_2168_C235};
    return p[126:63];
  endfunction

  function automatic logic [63:0] series_eval(logic [63:0] t, bit odd);
    logic [63:0] fk [0:18];
    logic [63:0] t2;
    logic [63:0] s;
    fk[0] = 64'h4000_0000_0000_0000;
    for (int k = 1; k <= 18; k++) fk[k] = fk[k-1] / 64'(k);
    t2 = fix_mul62(t, t);
    if (odd) begin
      s = fk[17];
      for (int k = 15; k >= 1; k -= 2) s = fk[k] - fix_mul62(t2, s);
      return fix_mul62(t, s);
    end
    s = fk[18];
    for (int k = 16; k >= 0; k -= 2) s = fk[k] - fix_mul62(t2, s);
    return s;
  endfunction

  function automatic logic [63:0] sine_of_turn(logic [63:0] ang);
    logic [63:0] a;
    logic [63:0] r;
    a = {1'b0, ang[62:0]};
    if (a > 64'h4000_0000_0000_0000) a = 64'h8000_0000_0000_0000 - a;
    if (a <= 64'h2000_0000_0000_0000) r = series_eval(turn_to_rad(a), 1'b1);
    else r = series_eval(turn_to_rad(64'h4000_0000_0000_0000 - a), 1'b0);
    return ang[63] ? 64'd0 - r : r;
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] round_q16(logic [63:0] v);
    logic [63:0] m;
    m = (magnitude(v) + (64'd1 << 45)) >> 46;
    return v[63] ? 64'd0 - m : m;
  endfunction

  function automatic logic [63:0] ratio_q16(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] acc;
    q = num / den;
    r = num % den;
    if (q >= 64'd65536) return 64'd1 << 32;
    acc = q;
    for (int i = 0; i < 17; i++) begin
      r = r << 1;
      acc = acc << 1;
      if (r >= den) begin
        r = r - den;
        acc[0] = 1'b1;
      end
    end
    acc = (acc + 64'd1) >> 1;
    return acc > (64'd1 << 32) ? (64'd1 << 32) : acc;
  endfunction

  function automatic logic [63:0] kernel_part(logic [63:0] num, logic [63:0] trig,
                                               logic [63:0] den, bit flip);
    logic [63:0] v;
    bit neg;
    v = ratio_q16(fix_mul62(magnitude(num), magnitude(trig)), magnitude(den));
    neg = num[63] ^ trig[63] ^ den[63] ^ flip;
    return neg ? 64'd0 - v : v;
  endfunction

  function automatic kernel_val_t kernel_value(bin_word_t w);
    kernel_val_t res;
    logic [63:0] n, f, b, ph, m, th1, th2, th3, q, r, x, y, num, den, re, im;
    bit neg;
    n = {47'd0, cur_fft_size};
    if (n < 64'd2) n = 64'd2;
    if (n > 64'd65536) n = 64'd65536;
    f = {32'd0, w.freq};
    ph = {w.phase, 48'd0};
    b = {32'd0, w.bin, 16'd0};
    neg = f < b;
    m = neg ? b - f : f - b;
    res.pole = 1'b0;
    if (m == 64'd0) begin
      re = round_q16(sine_of_turn(ph + 64'h4000_0000_0000_0000));
      im = 64'd0 - round_q16(sine_of_turn(ph));
    end else begin
      th1 = m << 47;
      q = m / n;
      r = m % n;
      x = r << 32;
      y = (x % n) << 15;
      th2 = (q << 47) + ((x / n) << 15) + y / n;
      if (neg) begin
        th1 = 64'd0 - th1;
        th2 = 64'd0 - th2;
      end
      num = sine_of_turn(th1);
      den = sine_of_turn(th2);
      if (den == 64'd0) begin
        re = '0;
        im = '0;
        res.pole = 1'b1;
      end else begin
        th3 = th1 + ph + th2;
        re = kernel_part(num, sine_of_turn(th3 + 64'h4000_0000_0000_0000), den, 1'b0);
        im = kernel_part(num, sine_of_turn(th3), den, !cur_cos_basis);
      end
    end
    res.re = re[dkbv_pkg::VAL_W-1:0];
    res.im = im[dkbv_pkg::VAL_W-1:0];
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    bin_word_t w;
    bit fire;
    if (rst_n) begin
      fire = start && !busy;
      if (fire) begin
        w.freq = in_true_frequency;
        w.phase = in_start_phase;
        w.bin = in_bin_index;
        kernel_expected.push_back(kernel_value(w));
      end
      if (!start || fire) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_true_frequency <= w.freq;
          in_start_phase <= w.phase;
          in_bin_index <= w.bin;
          start <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) gap_cnt = int'($urandom_range(1, 10));
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    kernel_val_t e;
    if (rst_n && out_valid) begin
      if (kernel_expected.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = kernel_expected.pop_front();
        if (out_value_real !== e.re) begin
          $error("value_real expected %h actual %h", e.re, out_value_real);
          errors++;
        end
        if (out_value_imag !== e.im) begin
          $error("value_imag expected %h actual %h", e.im, out_value_imag);
          errors++;
        end
        if (out_pole_flag !== e.pole) begin
          $error("pole_flag expected %b actual %b", e.pole, out_pole_flag);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [dkbv_pkg::CFG_IDX_W-1:0] idx,
                           logic [dkbv_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == dkbv_pkg::CFG_FFT_SIZE) cur_fft_size = val;
    else cur_cos_basis = val[0];
  endtask

  task automatic add_word(logic [31:0] f, logic [15:0] p, logic [15:0] b);
    bin_word_t w;
    w.freq = f;
    w.phase = p;
    w.bin = b;
    pending_words.push_back(w);
  endtask

  function automatic logic [63:0] eff_size();
    if (cur_fft_size < 17'd2) return 64'd2;
    if ({47'd0, cur_fft_size} > 64'd65536) return 64'd65536;
    return {47'd0, cur_fft_size};
  endfunction

  task automatic add_random(int count);
    logic [63:0] f, b, k;
    logic [15:0] p;
    for (int i = 0; i < count; i++) begin
      p = 16'($urandom);
      b = 64'($urandom_range(0, 65535));
      case ($urandom_range(0, 5))
        0: add_word(32'($urandom), p, 16'($urandom));
        1: add_word({b[15:0], 16'd0}, p, b[15:0]);
        2: begin
          k = 64'($urandom_range(1, 3)) * eff_size() * 64'd65536;
          f = (b << 16) + k;
          if (f > 64'hFFFF_FFFF) f = (b << 16) - k;
          if (f > 64'hFFFF_FFFF) f = 64'd0;
          add_word(f[31:0], p, b[15:0]);
        end
        3: begin
          f = (b << 16) + 64'($urandom_range(0, 32'h0008_0000)) - 64'h0004_0000;
          add_word(f[31:0], p, b[15:0]);
        end
        default: begin
          f = (b << 16) + 64'($urandom & 32'h00FF_FFFF) - 64'h0080_0000;
          add_word(f[31:0], p, b[15:0]);
        end
      endcase
    end
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || start || kernel_expected.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [16:0] sizes [0:7];
    bit bases [0:7];
    sizes = '{17'd2, 17'd0, 17'd1, 17'd65536, 17'd131071, 17'd7, 17'd1024, 17'd300};
    bases = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed words with reset settings
    add_word(32'h0000_0000, 16'h0000, 16'h0000);
    add_word(32'h0000_0000, 16'hFFFF, 16'hFFFF);
    add_word(32'hFFFF_FFFF, 16'h0000, 16'h0000);
    add_word(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    add_word(32'h0005_0000, 16'h4000, 16'h0005);
    add_word(32'h0005_0000, 16'h8000, 16'h0005);
    add_word(32'h0005_0000, 16'hC000, 16'h0005);
    add_word(32'h0005_0000, 16'h2000, 16'h0005);
    add_word(32'h0405_0000, 16'h1234, 16'h0005);
    add_word(32'h0005_0000, 16'h1234, 16'h0405);
    add_word(32'h0005_0001, 16'h0000, 16'h0005);
    add_word(32'h0004_FFFF, 16'h0000, 16'h0005);
    add_word(32'h0005_8000, 16'h3000, 16'h0005);
    add_word(32'h0003_0000, 16'h0100, 16'h0005);
    add_word(32'h0000_0001, 16'h0000, 16'h0000);
    add_word(32'h0001_0000, 16'h0000, 16'hFFFF);
    add_word(32'hFFFF_0000, 16'h7FFF, 16'h0000);
    add_word(32'h8000_0000, 16'h8000, 16'h8000);
    add_random(110);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(dkbv_pkg::CFG_FFT_SIZE, sizes[ph]);
      reg_write(dkbv_pkg::CFG_COSINE_BASIS, {16'd0, bases[ph]});
      if (ph == 7) idle_on = 1'b0;
      add_random(115);
      drain();
    end
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
